FILE: rtl/dtv_pkg.sv
// Package with shared types, character codes and calendar helpers for the date-time validator.
`timescale 1ns / 1ps

package dtv_pkg;

    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] POS_LIMIT = 5'd19;
    localparam logic [POS_W-1:0] POS_DASH_A = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B = 5'd7;
    localparam logic [POS_W-1:0] POS_SEP = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;
    localparam logic [POS_W-1:0] POS_CENT_END = 5'd1;
    localparam logic [POS_W-1:0] POS_YEAR_END = 5'd3;
    localparam logic [POS_W-1:0] POS_MONTH_END = 5'd6;
    localparam logic [POS_W-1:0] POS_DAY_END = 5'd9;
    localparam logic [POS_W-1:0] POS_HOUR_END = 5'd12;
    localparam logic [POS_W-1:0] POS_MINUTE_END = 5'd15;
    localparam logic [POS_W-1:0] POS_LAST_DATE = 5'd9;
    localparam logic [POS_W-1:0] POS_LAST_TIME = 5'd18;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_T = 8'h54;

    localparam logic [6:0] HOUR_MAX = 7'd23;
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [6:0] SECOND_MAX = 7'd59;

    // Accumulated fields after the current character, plus form and length status.
    typedef struct packed {
        logic [13:0] year;
        logic [6:0]  century;
        logic [6:0]  year_low;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic        form_error;
        logic        len_date;
        logic        len_time;
    } scan_t;

    typedef struct packed {
        logic        valid_res;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic        time_valid;
    } result_t;

    // Gregorian leap year from the century digits and the last two digits.
    function automatic logic is_leap(input logic [6:0] century, input logic [6:0] year_low);
        logic result;
        begin
            if (year_low != 7'd0) begin
                result = (year_low[1:0] == 2'b00);
            end else begin
                result = (century[1:0] == 2'b00);
            end
            return result;
        end
    endfunction

    // Days in a month, or zero when the month is out of range.
    function automatic logic [4:0] month_len(input logic [6:0] month, input logic leap);
        logic [4:0] result;
        begin
            unique case (month)
                7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: result = 5'd31;
                7'd4, 7'd6, 7'd9, 7'd11: result = 5'd30;
                7'd2: result = leap ? 5'd29 : 5'd28;
                default: result = 5'd0;
            endcase
            return result;
        end
    endfunction

endpackage

FILE: rtl/dtv_scan.sv
// Character scanner: position tracking, form checking and digit field accumulation.
`timescale 1ns / 1ps

module dtv_scan (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        char_code,
    input  logic              last_char,
    output dtv_pkg::scan_t    scan
);
    import dtv_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  century_reg, century_next;
    logic [6:0]  year_low_reg, year_low_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic        error_reg, error_next;
    logic        is_digit;
    logic [3:0]  digit;

    assign is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit = is_digit ? char_code[3:0] : 4'd0;

    always_comb begin
        year_next = year_reg;
        century_next = century_reg;
        year_low_next = year_low_reg;
        month_next = month_reg;
        day_next = day_reg;
        hour_next = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        error_next = error_reg;
        priority if (pos_reg >= POS_LIMIT) begin
            error_next = 1'b1;
        end else if (pos_reg == POS_DASH_A || pos_reg == POS_DASH_B) begin
            if (char_code != CH_DASH) error_next = 1'b1;
        end else if (pos_reg == POS_COLON_A || pos_reg == POS_COLON_B) begin
            if (char_code != CH_COLON) error_next = 1'b1;
        end else if (pos_reg == POS_SEP) begin
            if (char_code != CH_SPACE && char_code != CH_T) error_next = 1'b1;
        end else if (!is_digit) begin
            error_next = 1'b1;
        end else if (pos_reg <= POS_YEAR_END) begin
            year_next = 14'(year_reg * 14'd10 + {10'd0, digit});
            if (pos_reg <= POS_CENT_END) begin
                century_next = 7'(century_reg * 7'd10 + {3'd0, digit});
            end else begin
                year_low_next = 7'(year_low_reg * 7'd10 + {3'd0, digit});
            end
        end else if (pos_reg <= POS_MONTH_END) begin
            month_next = 7'(month_reg * 7'd10 + {3'd0, digit});
        end else if (pos_reg <= POS_DAY_END) begin
            day_next = 7'(day_reg * 7'd10 + {3'd0, digit});
        end else if (pos_reg <= POS_HOUR_END) begin
            hour_next = 7'(hour_reg * 7'd10 + {3'd0, digit});
        end else if (pos_reg <= POS_MINUTE_END) begin
            minute_next = 7'(minute_reg * 7'd10 + {3'd0, digit});
        end else begin
            second_next = 7'(second_reg * 7'd10 + {3'd0, digit});
        end
        pos_next = (pos_reg < POS_LIMIT) ? pos_reg + 5'd1 : pos_reg;
    end

    always_comb begin
        scan.year = year_next;
        scan.century = century_next;
        scan.year_low = year_low_next;
        scan.month = month_next;
        scan.day = day_next;
        scan.hour = hour_next;
        scan.minute = minute_next;
        scan.second = second_next;
        scan.form_error = error_next;
        scan.len_date = (pos_reg == POS_LAST_DATE);
        scan.len_time = (pos_reg == POS_LAST_TIME);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && last_char)) begin
            pos_reg <= '0;
            year_reg <= '0;
            century_reg <= '0;
            year_low_reg <= '0;
            month_reg <= '0;
            day_reg <= '0;
            hour_reg <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            error_reg <= 1'b0;
        end else if (step) begin
            pos_reg <= pos_next;
            year_reg <= year_next;
            century_reg <= century_next;
            year_low_reg <= year_low_next;
            month_reg <= month_next;
            day_reg <= day_next;
            hour_reg <= hour_next;
            minute_reg <= minute_next;
            second_reg <= second_next;
            error_reg <= error_next;
        end
    end

endmodule

FILE: rtl/dtv_check.sv
// Final range checks on the accumulated fields and formation of the result.
`timescale 1ns / 1ps

module dtv_check (
    input  dtv_pkg::scan_t   scan,
    output dtv_pkg::result_t result
);
    import dtv_pkg::*;

    logic       leap;
    logic [4:0] dim;
    logic       date_ok;
    logic       time_ok;
    logic       ok;

    assign leap = is_leap(scan.century, scan.year_low);
    assign dim = month_len(scan.month, leap);
    assign date_ok = !scan.form_error && (scan.len_date || scan.len_time) && (dim != 5'd0)
                     && (scan.day != 7'd0) && (scan.day <= {2'b00, dim});
    assign time_ok = (scan.hour <= HOUR_MAX) && (scan.minute <= MINUTE_MAX)
                     && (scan.second <= SECOND_MAX);
    assign ok = date_ok && (!scan.len_time || time_ok);

    always_comb begin
        result = '0;
        if (ok) begin
            result.valid_res = 1'b1;
            result.year = scan.year;
            result.month = scan.month[3:0];
            result.day = scan.day[4:0];
            if (scan.len_time) begin
                result.hour = scan.hour[4:0];
                result.minute = scan.minute[5:0];
                result.second = scan.second[5:0];
                result.time_valid = 1'b1;
            end
        end
    end

endmodule

FILE: rtl/datetime_text_validator.sv
// Top level of the date-time text validator: input register, scanner, checker and result register.
`timescale 1ns / 1ps
//
//  Channel | Ports                                         | Direction
//  --------+-----------------------------------------------+----------
//  input   | s_valid, s_ready, s_char_code, s_last_char    | one character per transaction
//  result  | m_valid, m_ready, m_valid_res .. m_time_valid | one transaction per string
//
//  One character is taken per cycle unless a last character is stalled; results are registered.
//  The input register feeds the scanner, whose fields pass through the checker into the
//  result register in the same cycle. Reset clears the position, accumulators and valid flags.
//  A held result stalls only a last character; other characters keep flowing.

module datetime_text_validator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic [13:0] m_year,
    output logic [3:0]  m_month,
    output logic [4:0]  m_day,
    output logic [4:0]  m_hour,
    output logic [5:0]  m_minute,
    output logic [5:0]  m_second,
    output logic        m_time_valid
);
    import dtv_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    scan_t       scan;
    result_t     result;
    logic        step;

    assign step = in_valid_reg && (!last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    dtv_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_code (char_reg),
        .last_char (last_reg),
        .scan      (scan)
    );

    dtv_check u_check (
        .scan   (scan),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            char_reg <= s_char_code;
            last_reg <= s_last_char;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step && last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && last_reg) begin
            out_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_valid_res = out_reg.valid_res;
    assign m_year = out_reg.year;
    assign m_month = out_reg.month;
    assign m_day = out_reg.day;
    assign m_hour = out_reg.hour;
    assign m_minute = out_reg.minute;
    assign m_second = out_reg.second;
    assign m_time_valid = out_reg.time_valid;

endmodule
